// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

  // Frame layout
  localparam int LENGTH_BYTES = 2;
  localparam int CHECK_BYTES  = 2;
  localparam int HDR_BYTES    = 1 + LENGTH_BYTES;

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [15:0] CHK_RESET = 16'hFFFF;
  localparam logic [15:0] CHK_MASK  = (CHECK_BYTES == 1) ? 16'h00FF : 16'hFFFF;

  typedef enum logic [3:0] {
    EV_TIMEOUT   = 4'd0,
    EV_PAYLOAD   = 4'd1,
    EV_GOOD      = 4'd2,
    EV_BAD_CHECK = 4'd3,
    EV_TOO_LONG  = 4'd4,
    EV_ACK       = 4'd5,
    EV_NAK       = 4'd6,
    EV_CANCEL    = 4'd7,
    EV_WAKE      = 4'd8
  } ev_t;

  typedef enum logic [2:0] {
    CFG_SYNC    = 3'd0,
    CFG_ACK     = 3'd1,
    CFG_BAD     = 3'd2,
    CFG_CANCEL  = 3'd3,
    CFG_MAX_LEN = 3'd4,
    CFG_TIMEOUT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [7:0]  ack_byte;
    logic [7:0]  bad_byte;
    logic [7:0]  cancel_byte;
    logic [15:0] max_frame_bytes;
    logic [15:0] byte_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    ev_t         event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_length;
    logic [7:0]  reply_byte;
    logic        reply_valid;
  } res_t;

  // One queue entry: an optional timeout ahead of an optional main result
  typedef struct packed {
    logic has_to;
    logic has_main;
    res_t main;
  } bundle_t;

  localparam res_t RES_ZERO = '{event_res: EV_TIMEOUT, payload_byte: 8'h00,
                                payload_index: 16'h0000, frame_length: 16'h0000,
                                reply_byte: 8'h00, reply_valid: 1'b0};

  function automatic logic [15:0] chk_init();
    return (CHECK_BYTES == 1) ? 16'h00FF : 16'hFFFF;
  endfunction

  // CRC-16/CCITT-FALSE byte update, or 8-bit XOR for a one-byte check
  function automatic logic [15:0] chk_update(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] x;
    x = acc[15:8] ^ b;
    x = x ^ (x >> 4);
    if (CHECK_BYTES == 1) begin
      return {8'h00, acc[7:0] ^ b};
    end
    return {acc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ----- rtl/sfr_front.sv -----
module sfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::cfg_t    cfg,
  input  logic             acc_i,
  input  logic             mode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             wake_i,
  output logic             push_o,
  output sfr_pkg::bundle_t bundle_o
);

  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] pl_r, pl_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic        run_r, run_nxt;

  logic        timed_out;
  logic [15:0] pos;
  logic [16:0] total_len;
  logic [16:0] new_len;
  sfr_pkg::bundle_t bnd;

  always_comb begin
    cnt_nxt   = cnt_r;
    pl_nxt    = pl_r;
    acc_nxt   = acc_r;
    rc_nxt    = rc_r;
    gap_nxt   = gap_r;
    run_nxt   = run_r;
    bnd       = '{has_to: 1'b0, has_main: 1'b0, main: sfr_pkg::RES_ZERO};
    timed_out = run_r && (gap_r >= cfg.byte_timeout_ticks);
    pos       = timed_out ? 16'h0000 : cnt_r;
    total_len = 17'(sfr_pkg::HDR_BYTES) + {1'b0, pl_r} + 17'(sfr_pkg::CHECK_BYTES);
    new_len   = 17'(sfr_pkg::HDR_BYTES) + {1'b0, {pl_r[7:0], rx_byte_i}}
              + 17'(sfr_pkg::CHECK_BYTES);

    if (acc_i && mode_i) begin
      if (run_r && gap_r != 16'hFFFF) begin
        gap_nxt = gap_r + 16'd1;
      end
    end else if (acc_i) begin
      bnd.has_to = timed_out;
      gap_nxt    = 16'h0000;
      cnt_nxt    = pos + 16'd1;
      if (timed_out) begin
        run_nxt = 1'b0;
      end

      if (pos == 16'h0000) begin
        if (rx_byte_i == cfg.sync_byte) begin
          run_nxt  = 1'b1;
          pl_nxt   = 16'h0000;
          rc_nxt   = 16'h0000;
          acc_nxt  = sfr_pkg::chk_init();
          if (!wake_i) begin
            bnd.has_main       = 1'b1;
            bnd.main.event_res = sfr_pkg::EV_WAKE;
          end
        end else begin
          // lone control byte: ack before nak before cancel
          if (wake_i) begin
            priority if (rx_byte_i == cfg.ack_byte) begin
              bnd.has_main       = 1'b1;
              bnd.main.event_res = sfr_pkg::EV_ACK;
            end else if (rx_byte_i == cfg.bad_byte) begin
              bnd.has_main       = 1'b1;
              bnd.main.event_res = sfr_pkg::EV_NAK;
            end else if (rx_byte_i == cfg.cancel_byte) begin
              bnd.has_main       = 1'b1;
              bnd.main.event_res = sfr_pkg::EV_CANCEL;
            end else begin
              // any other stray byte is dropped silently
              bnd.has_main = 1'b0;
            end
          end
          cnt_nxt = 16'h0000;
          run_nxt = 1'b0;
        end
      end else if (pos < 16'(sfr_pkg::HDR_BYTES)) begin
        pl_nxt = {pl_r[7:0], rx_byte_i};
        if (pos == 16'(sfr_pkg::HDR_BYTES - 1) && new_len > {1'b0, cfg.max_frame_bytes}) begin
          bnd.has_main          = 1'b1;
          bnd.main.event_res    = sfr_pkg::EV_TOO_LONG;
          bnd.main.frame_length = pl_nxt;
          cnt_nxt               = 16'h0000;
          run_nxt               = 1'b0;
        end
      end else if ({1'b0, pos} < 17'(sfr_pkg::HDR_BYTES) + {1'b0, pl_r}) begin
        acc_nxt                = sfr_pkg::chk_update(acc_r, rx_byte_i);
        bnd.has_main           = 1'b1;
        bnd.main.event_res     = sfr_pkg::EV_PAYLOAD;
        bnd.main.payload_byte  = rx_byte_i;
        bnd.main.payload_index = pos - 16'(sfr_pkg::HDR_BYTES);
      end else begin
        rc_nxt = {rc_r[7:0], rx_byte_i};
        if ({1'b0, pos} + 17'd1 >= total_len) begin
          bnd.has_main          = 1'b1;
          bnd.main.frame_length = pl_r;
          bnd.main.reply_valid  = 1'b1;
          if ((acc_r & sfr_pkg::CHK_MASK) == (rc_nxt & sfr_pkg::CHK_MASK)) begin
            bnd.main.event_res  = sfr_pkg::EV_GOOD;
            bnd.main.reply_byte = cfg.ack_byte;
          end else begin
            bnd.main.event_res  = sfr_pkg::EV_BAD_CHECK;
            bnd.main.reply_byte = cfg.bad_byte;
          end
          cnt_nxt = 16'h0000;
          run_nxt = 1'b0;
        end
      end
    end
  end

  assign bundle_o = bnd;
  assign push_o   = acc_i && !mode_i && (bnd.has_to || bnd.has_main);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 16'h0000;
      pl_r  <= 16'h0000;
      acc_r <= sfr_pkg::CHK_RESET;
      rc_r  <= 16'h0000;
      gap_r <= 16'h0000;
      run_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      pl_r  <= pl_nxt;
      acc_r <= acc_nxt;
      rc_r  <= rc_nxt;
      gap_r <= gap_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// ----- rtl/sfr_queue.sv -----
module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  sfr_pkg::bundle_t data_i,
  input  logic             pop_i,
  output sfr_pkg::bundle_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  sfr_pkg::bundle_t mem_r [sfr_pkg::QDEPTH];

  logic [sfr_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sfr_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sfr_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_r == (sfr_pkg::QAW+1)'(sfr_pkg::QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (sfr_pkg::QAW+1)'(do_push) - (sfr_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/sfr_back.sv -----
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::bundle_t head_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sfr_pkg::res_t    res_o,
  output logic             last_o
);

  sfr_pkg::res_t out_r, out_nxt;
  logic          last_r, last_nxt;
  logic          valid_r, valid_nxt;
  logic          phase_r, phase_nxt;   // timeout of the head entry already sent
  logic          load;

  assign load = !q_empty_i && (!valid_r || pop_i);

  always_comb begin
    out_nxt   = out_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !pop_i;
    phase_nxt = phase_r;
    q_pop_o   = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (head_i.has_to && head_i.has_main && !phase_r) begin
        out_nxt   = sfr_pkg::RES_ZERO;
        last_nxt  = 1'b0;
        phase_nxt = 1'b1;
      end else if (head_i.has_main) begin
        out_nxt   = head_i.main;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        q_pop_o   = 1'b1;
      end else begin
        out_nxt   = sfr_pkg::RES_ZERO;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        q_pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign empty_o = !valid_r;
  assign res_o   = out_r;
  assign last_o  = last_r;

endmodule

// ----- rtl/serial_frame_receiver_core.sv -----
// Frame receiver for a sync / big-endian length / payload / big-endian check
// byte stream (CRC-16/CCITT-FALSE check). Each beat on the input queue is
// either a received byte or a 1 ms tick; ticks only advance the inter-byte
// gap timer and give no result. Accepted bytes are classified in the cycle
// they arrive and their results (at most two: a timeout, then the byte's
// own event) land in a four-entry queue; a back stage drains that queue
// into a registered output one result per cycle while pop is held. The
// block takes one beat per cycle while the queue has room; a byte with two
// results holds the output for both of them, so a run of such bytes is
// slowed to the output's pace once the queue has filled. A result is held
// in its queue entry, then in the output register. Payload bytes come
// out as they arrive and the verdict (good or bad check, with the reply
// byte) follows the last check byte; a frame whose total length exceeds
// max_frame_bytes is dropped at the end of its header. An over-long gap is
// reported when the next byte comes in, and that byte then starts afresh.
// Configuration writes must only be made while the block is idle.
module serial_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        push,
  output logic        full,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_wake_line_high,

  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_reply_byte,
  output logic        out_reply_valid,
  output logic        out_last,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sfr_pkg::cfg_t    cfg_r, cfg_nxt;
  sfr_pkg::bundle_t f_bundle;
  sfr_pkg::bundle_t q_head;
  sfr_pkg::res_t    res;
  logic             f_push;
  logic             q_empty, q_full, q_pop;
  logic             in_acc;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sfr_pkg::CFG_SYNC:    cfg_nxt.sync_byte          = cfg_data[7:0];
        sfr_pkg::CFG_ACK:     cfg_nxt.ack_byte           = cfg_data[7:0];
        sfr_pkg::CFG_BAD:     cfg_nxt.bad_byte           = cfg_data[7:0];
        sfr_pkg::CFG_CANCEL:  cfg_nxt.cancel_byte        = cfg_data[7:0];
        sfr_pkg::CFG_MAX_LEN: cfg_nxt.max_frame_bytes    = cfg_data;
        sfr_pkg::CFG_TIMEOUT: cfg_nxt.byte_timeout_ticks = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sync_byte: 8'd126, ack_byte: 8'd6, bad_byte: 8'd21, cancel_byte: 8'd24,
                 max_frame_bytes: 16'd256, byte_timeout_ticks: 16'd30};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: beat accepted whenever the queue has room
  assign full   = q_full;
  assign in_acc = push && !q_full;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc_i     (in_acc),
    .mode_i    (in_mode),
    .rx_byte_i (in_rx_byte),
    .wake_i    (in_wake_line_high),
    .push_o    (f_push),
    .bundle_o  (f_bundle)
  );

  sfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .data_i  (f_bundle),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: splits each entry into one or two result beats
  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res),
    .last_o    (out_last)
  );

  assign out_event_res     = res.event_res;
  assign out_payload_byte  = res.payload_byte;
  assign out_payload_index = res.payload_index;
  assign out_frame_length  = res.frame_length;
  assign out_reply_byte    = res.reply_byte;
  assign out_reply_valid   = res.reply_valid;

  // Ticks never produce a queue entry
  a_tick_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode) |-> !f_push)
    else $error("tick produced a result entry");

  // Only a leading timeout is shown without last
  a_nonlast_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_event_res == sfr_pkg::EV_TIMEOUT))
    else $error("non-final beat that is not a timeout");

  // The entry behind a leading timeout stays queued until its main result goes
  a_split_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> !q_empty)
    else $error("queue drained while a split entry was pending");

  // Reply only with a verdict
  a_reply_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_reply_valid == (out_event_res == sfr_pkg::EV_GOOD ||
                                    out_event_res == sfr_pkg::EV_BAD_CHECK)))
    else $error("reply flag does not match verdict");

endmodule

// ----- tb/sv/frame_result_checker.sv -----
`timescale 1ns / 1ps

package frame_check_pkg;

  localparam logic [15:0] CHECK_SEED = (sfr_pkg::CHECK_BYTES == 1) ? 16'h00FF : 16'hFFFF;
  localparam logic [15:0] CHECK_MASK = (sfr_pkg::CHECK_BYTES == 1) ? 16'h00FF : 16'hFFFF;

  // Bitwise CRC-16/CCITT-FALSE step, or running XOR for a one-byte check
  function automatic logic [15:0] check_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    if (sfr_pkg::CHECK_BYTES == 1) begin
      return {8'h00, acc[7:0] ^ b};
    end
    c = acc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

module frame_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_wake_line_high,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  out_event_res,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_payload_index,
  input  logic [15:0] out_frame_length,
  input  logic [7:0]  out_reply_byte,
  input  logic        out_reply_valid,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);
  import sfr_pkg::*;
  import frame_check_pkg::*;

  typedef struct packed {
    res_t body;
    logic last;
  } frame_result_t;

  frame_result_t expected_q[$];

  // register copy
  logic [7:0]  sync_r, ack_r, bad_r, cancel_r;
  logic [15:0] max_len_r, gap_limit_r;

  // deframer state
  logic [15:0] byte_pos, hdr_len, crc_acc, rx_check, gap_ticks;
  logic        gap_armed;

  int bad_count = 0;
  int n_checked = 0;

  function automatic frame_result_t make_result(input ev_t ev, input logic [7:0] pb,
                                                input logic [15:0] pi, input logic [15:0] fl,
                                                input logic [7:0] rb, input logic rv);
    frame_result_t r;
    r.body.event_res     = ev;
    r.body.payload_byte  = pb;
    r.body.payload_index = pi;
    r.body.frame_length  = fl;
    r.body.reply_byte    = rb;
    r.body.reply_valid   = rv;
    r.last               = 1'b0;
    return r;
  endfunction

  function automatic string show(input frame_result_t r);
    return $sformatf("ev %0d byte %02h idx %0d len %0d reply %02h/%0b last %0b",
                     r.body.event_res, r.body.payload_byte, r.body.payload_index,
                     r.body.frame_length, r.body.reply_byte, r.body.reply_valid, r.last);
  endfunction

  task automatic predict_beat(input logic is_tick, input logic [7:0] b, input logic wake);
    frame_result_t fresh [2];
    int n;
    int k;
    int unsigned pos;
    int unsigned whole_len;
    n = 0;
    if (is_tick) begin
      if (gap_armed && gap_ticks != 16'hFFFF) gap_ticks = gap_ticks + 16'd1;
    end else begin
      // expired gap: report it, then treat this byte as a fresh first byte
      if (gap_armed && gap_ticks >= gap_limit_r) begin
        fresh[n] = make_result(EV_TIMEOUT, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        n++;
        byte_pos  = 16'd0;
        gap_armed = 1'b0;
      end
      gap_ticks = 16'd0;
      pos       = byte_pos;
      byte_pos  = byte_pos + 16'd1;
      if (pos == 0) begin
        if (b == sync_r) begin
          gap_armed = 1'b1;
          hdr_len   = 16'd0;
          rx_check  = 16'd0;
          crc_acc   = CHECK_SEED;
          if (!wake) begin
            fresh[n] = make_result(EV_WAKE, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
            n++;
          end
        end else begin
          if (wake && b == ack_r) begin
            fresh[n] = make_result(EV_ACK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
            n++;
          end else if (wake && b == bad_r) begin
            fresh[n] = make_result(EV_NAK, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
            n++;
          end else if (wake && b == cancel_r) begin
            fresh[n] = make_result(EV_CANCEL, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
            n++;
          end
          byte_pos  = 16'd0;
          gap_armed = 1'b0;
        end
      end else if (pos < HDR_BYTES) begin
        hdr_len = {hdr_len[7:0], b};
        if (pos == HDR_BYTES - 1) begin
          whole_len = HDR_BYTES + hdr_len + CHECK_BYTES;
          if (whole_len > max_len_r) begin
            fresh[n] = make_result(EV_TOO_LONG, 8'h00, 16'h0000, hdr_len, 8'h00, 1'b0);
            n++;
            byte_pos  = 16'd0;
            gap_armed = 1'b0;
          end
        end
      end else if (pos < HDR_BYTES + hdr_len) begin
        crc_acc  = check_step(crc_acc, b);
        fresh[n] = make_result(EV_PAYLOAD, b, 16'(pos - HDR_BYTES), 16'h0000, 8'h00, 1'b0);
        n++;
      end else begin
        rx_check = {rx_check[7:0], b};
        if (pos + 1 >= HDR_BYTES + hdr_len + CHECK_BYTES) begin
          if ((crc_acc & CHECK_MASK) == (rx_check & CHECK_MASK))
            fresh[n] = make_result(EV_GOOD, 8'h00, 16'h0000, hdr_len, ack_r, 1'b1);
          else
            fresh[n] = make_result(EV_BAD_CHECK, 8'h00, 16'h0000, hdr_len, bad_r, 1'b1);
          n++;
          byte_pos  = 16'd0;
          gap_armed = 1'b0;
        end
      end
      for (k = 0; k < n; k++) begin
        fresh[k].last = (k == n - 1);
        expected_q.push_back(fresh[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    if (!rst_n) begin
      sync_r      = 8'd126;
      ack_r       = 8'd6;
      bad_r       = 8'd21;
      cancel_r    = 8'd24;
      max_len_r   = 16'd256;
      gap_limit_r = 16'd30;
      byte_pos    = 16'd0;
      hdr_len     = 16'd0;
      crc_acc     = 16'hFFFF;
      rx_check    = 16'd0;
      gap_ticks   = 16'd0;
      gap_armed   = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SYNC:    sync_r      = cfg_data[7:0];
          CFG_ACK:     ack_r       = cfg_data[7:0];
          CFG_BAD:     bad_r       = cfg_data[7:0];
          CFG_CANCEL:  cancel_r    = cfg_data[7:0];
          CFG_MAX_LEN: max_len_r   = cfg_data;
          CFG_TIMEOUT: gap_limit_r = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        seen.body.event_res     = ev_t'(out_event_res);
        seen.body.payload_byte  = out_payload_byte;
        seen.body.payload_index = out_payload_index;
        seen.body.frame_length  = out_frame_length;
        seen.body.reply_byte    = out_reply_byte;
        seen.body.reply_valid   = out_reply_valid;
        seen.last               = out_last;
        if (expected_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result with nothing expected: %s", $realtime, show(seen));
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (seen !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: result %0d wrong", $realtime, n_checked);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      if (push && !full) predict_beat(in_mode, in_rx_byte, in_wake_line_high);
    end
    mismatches <= bad_count;
    checked    <= n_checked;
    pending    <= expected_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;
  import frame_check_pkg::*;

  // cycles without any accepted beat before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // cycles allowed after the last result, covering the queue and the output register
  localparam int SETTLE_CYCLES = 8;
  localparam int BEATS_PER_PHASE = 165;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_mode;
  logic [7:0]  in_rx_byte;
  logic        in_wake_line_high;
  logic        empty;
  logic        pop;
  logic [3:0]  out_event_res;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic [15:0] out_frame_length;
  logic [7:0]  out_reply_byte;
  logic        out_reply_valid;
  logic        out_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int checked;

  // stimulus view of the current register settings
  logic [7:0] sync_v, ack_v, bad_v, cancel_v;
  int         max_v, gap_v;

  int tx_idle_pct;
  int rx_stall_pct;
  int beats_sent;
  int frames_sent;
  int quiet;

  serial_frame_receiver_core i_dut (
    .clk, .rst_n,
    .push, .full, .in_mode, .in_rx_byte, .in_wake_line_high,
    .empty, .pop, .out_event_res, .out_payload_byte, .out_payload_index,
    .out_frame_length, .out_reply_byte, .out_reply_valid, .out_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  frame_result_checker i_chk (
    .clk, .rst_n,
    .push, .full, .in_mode, .in_rx_byte, .in_wake_line_high,
    .empty, .pop, .out_event_res, .out_payload_byte, .out_payload_index,
    .out_frame_length, .out_reply_byte, .out_reply_valid, .out_last,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pending, .checked
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side: pop is re-rolled every falling edge, so stalls land on any
  // phase of the output stage, including the second result of a byte.
  always @(negedge clk) pop <= ($urandom_range(99) >= rx_stall_pct);

  // Watchdog: any accepted beat on either side counts as progress.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(65535));
  endfunction

  // One input beat. Entered and left at a falling edge; idle cycles are
  // rolled one at a time so the gaps are geometric rather than fixed.
  task automatic send_beat(input logic is_tick, input logic [7:0] b, input logic wake);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push              <= 1'b1;
    in_mode           <= is_tick;
    in_rx_byte        <= b;
    in_wake_line_high <= wake;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Ticks carry random byte and wake values; the block must ignore them.
  task automatic send_ticks(input int count);
    repeat (count) send_beat(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Builds sync, length, payload and check. stop_at truncates the frame
  // (negative sends it all); gap_len ticks go in ahead of byte gap_at.
  task automatic send_frame(input int len, input bit spoil, input bit wake_low,
                            input int stop_at, input int gap_at, input int gap_len,
                            input int fill);
    logic [7:0]  frame_q[$];
    logic [15:0] acc;
    logic [7:0]  v;
    logic [7:0]  w;
    int          k;
    int          n_send;
    acc = CHECK_SEED;
    frame_q.push_back(sync_v);
    for (k = LENGTH_BYTES - 1; k >= 0; k--) frame_q.push_back(len[8*k +: 8]);
    for (k = 0; k < len; k++) begin
      v   = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
      acc = check_step(acc, v);
      frame_q.push_back(v);
    end
    if (spoil) begin
      // low byte always disturbed, so the check is wrong for either width
      v   = 8'($urandom_range(1, 255));
      w   = 8'($urandom_range(255));
      acc = acc ^ {w, v};
    end
    for (k = CHECK_BYTES - 1; k >= 0; k--) frame_q.push_back(acc[8*k +: 8]);
    n_send = (stop_at < 0 || stop_at > frame_q.size()) ? frame_q.size() : stop_at;
    for (k = 0; k < n_send; k++) begin
      if (k == gap_at)
        send_ticks(gap_len);
      else if (k > 0 && gap_v > 1 && $urandom_range(6) == 0)
        // short gap, always inside the limit
        send_ticks($urandom_range(1, (gap_v > 4) ? 3 : gap_v - 1));
      send_beat(1'b0, frame_q[k], (k == 0) ? !wake_low : 1'($urandom_range(1)));
    end
    frames_sent++;
  endtask

  // Mostly short payloads that fit the current frame limit, now and then longer.
  function automatic int pick_len();
    int room;
    room = max_v - HDR_BYTES - CHECK_BYTES;
    if (room <= 0) return $urandom_range(3);
    if ($urandom_range(9) == 0) return $urandom_range(0, (room < 48) ? room : 48);
    return $urandom_range(0, (room < 8) ? room : 8);
  endfunction

  task automatic random_episode();
    int pick;
    int len;
    int total;
    pick  = $urandom_range(99);
    len   = pick_len();
    total = HDR_BYTES + len + CHECK_BYTES;
    if (pick < 62) begin
      // well-formed frame; some spoiled checks, some wake requests
      send_frame(len, $urandom_range(4) == 0, $urandom_range(6) == 0, -1, -1, 0, -1);
    end else if (pick < 70) begin
      // gap of at least the limit somewhere inside the frame (a plain frame when the limit is over 64)
      if (gap_v <= 64)
        send_frame(len, 1'b0, 1'b0, -1, $urandom_range(1, total - 1),
                   gap_v + $urandom_range(2), -1);
      else
        send_frame(len, 1'b0, 1'b0, -1, -1, 0, -1);
    end else if (pick < 77) begin
      // truncated frame, usually flushed by an expired gap
      send_frame(len, 1'b0, 1'b0, $urandom_range(1, total - 1), -1, 0, -1);
      if (gap_v <= 64 && $urandom_range(3) != 0) send_ticks(gap_v + 1);
    end else if (pick < 82) begin
      // header announcing a frame over the limit
      len = max_v - HDR_BYTES - CHECK_BYTES + 1;
      if (len < 0) len = 0;
      len = len + $urandom_range(20);
      if (len > 65535) len = 65535;
      send_frame(len, 1'b0, $urandom_range(3) == 0, HDR_BYTES, -1, 0, -1);
    end else begin
      case ($urandom_range(3))
        0: begin
          case ($urandom_range(2))
            0: send_beat(1'b0, ack_v, 1'($urandom_range(1)));
            1: send_beat(1'b0, bad_v, 1'($urandom_range(1)));
            default: send_beat(1'b0, cancel_v, 1'($urandom_range(1)));
          endcase
        end
        1: send_beat(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
        2: send_ticks($urandom_range(1, 3));
        default: send_beat(1'b0, sync_v, 1'($urandom_range(1)));
      endcase
    end
  endtask

  // Stop sending, let every expected result drain, then allow for a tick
  // beat that may still be in flight with no result behind it.
  task automatic wait_for_quiet();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] s, input logic [15:0] a,
                              input logic [15:0] b, input logic [15:0] c,
                              input logic [15:0] m, input logic [15:0] t);
    write_reg(CFG_SYNC, s);
    write_reg(CFG_ACK, a);
    write_reg(CFG_BAD, b);
    write_reg(CFG_CANCEL, c);
    write_reg(CFG_MAX_LEN, m);
    write_reg(CFG_TIMEOUT, t);
    sync_v   = s[7:0];
    ack_v    = a[7:0];
    bad_v    = b[7:0];
    cancel_v = c[7:0];
    max_v    = m;
    gap_v    = t;
  endtask

  initial begin
    int ph;
    int target;
    rst_n             = 1'b0;
    push              = 1'b0;
    in_mode           = 1'b0;
    in_rx_byte        = 8'h00;
    in_wake_line_high = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = 16'h0000;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    beats_sent        = 0;
    frames_sent       = 0;
    // register values straight out of reset
    sync_v   = 8'd126;
    ack_v    = 8'd6;
    bad_v    = 8'd21;
    cancel_v = 8'd24;
    max_v    = 256;
    gap_v    = 30;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats on reset values, no idling.
    // Lone control bytes with the wake line high, then one with it low.
    send_beat(1'b0, ack_v, 1'b1);
    send_beat(1'b0, bad_v, 1'b1);
    send_beat(1'b0, cancel_v, 1'b1);
    send_beat(1'b0, ack_v, 1'b0);
    // stray bytes at both extremes, and a tick with no frame open
    send_beat(1'b0, 8'hFF, 1'b1);
    send_beat(1'b0, 8'h00, 1'b1);
    send_beat(1'b1, 8'hA5, 1'b0);
    // sync with the wake line low, empty payload
    send_frame(0, 1'b0, 1'b1, -1, -1, 0, -1);
    // spoiled check over an all-zero payload
    send_frame(1, 1'b1, 1'b0, -1, -1, 0, 8'h00);
    // good check over an all-ones payload
    send_frame(2, 1'b0, 1'b0, -1, -1, 0, 8'hFF);
    // largest length field: dropped at the end of the header
    send_frame(65535, 1'b0, 1'b0, HDR_BYTES, -1, 0, -1);

    for (ph = 0; ph < 8; ph++) begin
      // pause until everything is out before touching the registers
      wait_for_quiet();
      case (ph)
        0: begin
          program_regs(16'd126, 16'd6, 16'd21, 16'd24, 16'd256, 16'd30);
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          program_regs(rnd16(), rnd16(), rnd16(), rnd16(),
                       16'($urandom_range(16, 300)), 16'($urandom_range(1, 40)));
          tx_idle_pct  = 54;
          rx_stall_pct = 0;
        end
        2: begin
          program_regs(16'h0000, 16'h00FF, 16'h00FF, 16'h0000, 16'hFFFF, 16'd3);
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          // a gap of exactly the limit still counts as expired
          send_beat(1'b0, sync_v, 1'b1);
          send_ticks(3);
          send_beat(1'b0, 8'h5A, 1'b1);
          rx_stall_pct = 54;
        end
        3: begin
          program_regs(16'h00FF, 16'h0000, 16'h0000, 16'h00FF, 16'd4, 16'd1);
          tx_idle_pct  = 13;
          rx_stall_pct = 13;
          // one tick over a one-tick limit, then sync again
          send_beat(1'b0, sync_v, 1'b1);
          send_ticks(1);
          send_beat(1'b0, sync_v, 1'b1);
        end
        4: begin
          // limit below the header and a zero gap limit
          program_regs(rnd16(), rnd16(), rnd16(), rnd16(), 16'd0, 16'd0);
          tx_idle_pct  = 0;
          rx_stall_pct = 54;
        end
        5: begin
          program_regs(rnd16(), rnd16(), rnd16(), rnd16(),
                       16'($urandom_range(6, 40)), 16'($urandom_range(2, 12)));
          tx_idle_pct  = 54;
          rx_stall_pct = 0;
        end
        6: begin
          program_regs(rnd16(), rnd16(), rnd16(), rnd16(),
                       16'($urandom_range(5, 600)), 16'($urandom_range(1, 40)));
          tx_idle_pct  = 13;
          rx_stall_pct = 13;
        end
        default: begin
          program_regs(rnd16(), rnd16(), rnd16(), rnd16(),
                       16'($urandom_range(20, 200)), 16'($urandom_range(3, 30)));
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      target = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < target) random_episode();
    end

    wait_for_quiet();

    $display("covered %0d beats in %0d frames over 8 register settings,", beats_sent,
             frames_sent);
    $display("incl. a gap right at the limit; %0d results compared, %0d wrong", checked,
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/serial_frame_receiver_core.sv
tb/sv/frame_result_checker.sv
tb/sv/testbench.sv
